/* sv/skt_pkg.sv */
// Shared types and constants for the sorted key table.
`default_nettype none
package skt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int KEY_W       = 64;
	localparam int PAY_W       = 32;

	// operation codes
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DUP  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_MISS = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PAY_W-1:0] found_payload;
		logic [6:0]       entry_count;
	} rsp_item_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} skt_state_t;

endpackage
`default_nettype wire

/* sv/skt_cell.sv */
// One slot of the sorted table: holds a key and payload, compares and shifts.
`default_nettype none
module skt_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire skt_pkg::cell_ctl_t       ctl,
	input  wire logic [skt_pkg::IDX_W-1:0] idx,
	input  wire logic [skt_pkg::CNT_W-1:0] count,
	input  wire logic [skt_pkg::KEY_W-1:0] cmp_key,
	input  wire logic [skt_pkg::PAY_W-1:0] new_pay,
	input  wire logic                     prev_gt,
	input  wire logic [skt_pkg::KEY_W-1:0] prev_key,
	input  wire logic [skt_pkg::PAY_W-1:0] prev_pay,
	output logic                          gt_q,
	output logic                          eq_q,
	output logic [skt_pkg::KEY_W-1:0]     key_q,
	output logic [skt_pkg::PAY_W-1:0]     pay_q
);
	import skt_pkg::*;

	logic occ;
	logic at_end;

	// slot holds a live entry below the count; the slot at the count is the tail
	assign occ    = CNT_W'(idx) < count;
	assign at_end = CNT_W'(idx) == count;

	// compare flags, taken in the compare cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			gt_q <= occ && (key_q > cmp_key);
			eq_q <= occ && (key_q == cmp_key);
		end
	end

	// insert: take the neighbor's entry if it moves up, else the new one at the insert point
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			if (prev_gt) begin
				key_q <= prev_key;
				pay_q <= prev_pay;
			end else if (gt_q || at_end) begin
				key_q <= cmp_key;
				pay_q <= new_pay;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/sorted_key_table_unit.sv */
// Sorted key table: request decode, cell row, entry count and result register.
//
// Usage: a request (func, key, payload) is transferred on req when req_valid
// is high and req_stall is low. Each request yields exactly one response
// (status, found_payload, entry_count) on rsp, transferred when rsp_valid is
// high and rsp_stall is low.
// A row of cells compares the key in all slots in parallel in the compare
// state; the update state shifts entries up by one slot for an insert and
// loads the response register. A new request is taken only when the block
// is idle or in the cycle the response is written, never during compare.
// While an earlier response is still waiting under stall, a request taken
// from idle waits in the update state and no further request is taken.
// Reset: the entry count clears to zero and no response is pending; slot
// contents are not cleared and become valid only as entries are inserted.
// When the receiver stalls, the finished response holds in its register, the
// next result waits in the update stage and req_stall stays high until the
// response drains.
`default_nettype none
module sorted_key_table_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire skt_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output skt_pkg::rsp_item_t      rsp
);
	import skt_pkg::*;

	skt_state_t state_q, state_d;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q, rsp_d;

	logic accept, out_free, finish;
	logic full, hit, do_insert;
	logic [PAY_W-1:0] found_pay;
	cell_ctl_t ctl;

	logic [TABLE_DEPTH-1:0] gt_vec, eq_vec;
	logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
	logic [PAY_W-1:0] cell_pay [TABLE_DEPTH];

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == S_UPD) && out_free;
	assign req_stall = !((state_q == S_IDLE) || finish);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (finish) state_d = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.func;
			key_q <= req.key;
			pay_q <= req.payload;
		end
	end

	// match reduction over the row; at most one slot can match
	always_comb begin
		found_pay = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (eq_vec[i]) found_pay = found_pay | cell_pay[i];
		end
	end

	assign hit  = |eq_vec;
	assign full = count_q == CNT_W'(TABLE_DEPTH);

	// response and count update
	always_comb begin
		rsp_d     = '0;
		count_d   = count_q;
		do_insert = 1'b0;
		unique case (op_q)
			FUNC_INSERT: begin
				if (full) begin
					rsp_d.status = STAT_FULL;
				end else if (hit) begin
					rsp_d.status = STAT_DUP;
				end else begin
					rsp_d.status = STAT_OK;
					do_insert    = 1'b1;
					count_d      = count_q + CNT_W'(1);
				end
			end
			FUNC_LOOKUP: begin
				if (hit) begin
					rsp_d.status        = STAT_OK;
					rsp_d.found_payload = found_pay;
				end else begin
					rsp_d.status = STAT_MISS;
				end
			end
			FUNC_CLEAR: begin
				count_d = '0;
			end
			default: begin
				rsp_d.status = STAT_OK;
			end
		endcase
		rsp_d.entry_count = 7'(count_d);
	end

	assign ctl.cmp_en   = (state_q == S_CMP);
	assign ctl.shift_en = finish && do_insert;

	// count and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			count_q     <= count_d;
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) rsp_q <= rsp_d;
	end

	// row of cells, each fed by its lower neighbor
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic             p_gt;
		logic [KEY_W-1:0] p_key;
		logic [PAY_W-1:0] p_pay;

		if (i == 0) begin : g_head
			assign p_gt  = 1'b0;
			assign p_key = '0;
			assign p_pay = '0;
		end else begin : g_link
			assign p_gt  = gt_vec[i-1];
			assign p_key = cell_key[i-1];
			assign p_pay = cell_pay[i-1];
		end

		skt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.idx      (IDX_W'(i)),
			.count    (count_q),
			.cmp_key  (key_q),
			.new_pay  (pay_q),
			.prev_gt  (p_gt),
			.prev_key (p_key),
			.prev_pay (p_pay),
			.gt_q     (gt_vec[i]),
			.eq_q     (eq_vec[i]),
			.key_q    (cell_key[i]),
			.pay_q    (cell_pay[i])
		);
	end

endmodule
`default_nettype wire

/* bench/tb_sorted_key_table_unit.sv */
// Self-checking testbench for the sorted key table: random traffic, stalls and a scoreboard.
`timescale 1ns / 100ps
module tb_sorted_key_table_unit;
	import skt_pkg::*;

	// operation code the block ignores
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int ITEM_TARGET = 850;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		req_item_t body;
		bit        drain;
	} backlog_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	sorted_key_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// shadow table used for prediction
	logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	logic [PAY_W-1:0] tbl_pay [TABLE_DEPTH];
	int               tbl_used = 0;

	backlog_t   req_backlog [$];
	rsp_item_t  rsp_due [$];
	logic [63:0] live_keys [$];   // keys the stimulus believes are stored

	int req_sent = 0;
	int req_xfers = 0;
	int rsp_seen = 0;
	int n_queued = 0;
	int err_cnt = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int n_stored = 0, n_dup = 0, n_full = 0, n_hit = 0, n_miss = 0, n_clear = 0;

	initial forever #5 clk = ~clk;

	// Predict one request's response and update the shadow table
	function automatic rsp_item_t table_apply(req_item_t r);
		rsp_item_t o;
		int        pos;
		o.status        = STAT_OK;
		o.found_payload = '0;
		pos = 0;
		while (pos < tbl_used && tbl_key[pos] < r.key)
			pos++;
		case (r.func)
			FUNC_INSERT: begin
				if (tbl_used >= TABLE_DEPTH)
					o.status = STAT_FULL;
				else if (pos < tbl_used && tbl_key[pos] == r.key)
					o.status = STAT_DUP;
				else begin
					for (int i = tbl_used; i > pos; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_pay[i] = tbl_pay[i-1];
					end
					tbl_key[pos] = r.key;
					tbl_pay[pos] = r.payload;
					tbl_used++;
				end
			end
			FUNC_LOOKUP: begin
				if (pos < tbl_used && tbl_key[pos] == r.key)
					o.found_payload = tbl_pay[pos];
				else
					o.status = STAT_MISS;
			end
			FUNC_CLEAR: tbl_used = 0;
			default: ;
		endcase
		o.entry_count = tbl_used[6:0];
		return o;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// random key, biased toward both ends of the key range
	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		k = 64'($urandom_range(0, 31));
		case ($urandom_range(0, 9))
			0: return k;
			1: return {64{1'b1}} - k;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] known_key();
		if (live_keys.size() == 0)
			return fresh_key();
		return live_keys[$urandom_range(0, live_keys.size() - 1)];
	endfunction

	function automatic logic [31:0] rand_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input logic [1:0] f, input logic [63:0] k, input logic [31:0] p);
		backlog_t b;
		bit       hit;
		b.body.func    = f;
		b.body.key     = k;
		b.body.payload = p;
		b.drain        = 0;
		req_backlog.push_back(b);
		if (f != FUNC_SPARE)
			n_queued++;
		if (f == FUNC_CLEAR)
			live_keys.delete();
		else if (f == FUNC_INSERT && live_keys.size() < TABLE_DEPTH) begin
			hit = 0;
			foreach (live_keys[i])
				if (live_keys[i] == k)
					hit = 1;
			if (!hit)
				live_keys.push_back(k);
		end
	endtask

	// sender waits here until every response is back
	task automatic queue_drain();
		backlog_t b;
		b.body  = '0;
		b.drain = 1;
		req_backlog.push_back(b);
	endtask

	// clear, fill to capacity, then hit the full table with new and present keys
	task automatic fill_round();
		queue_op(FUNC_CLEAR, fresh_key(), rand_payload());
		while (live_keys.size() < TABLE_DEPTH) begin
			if ($urandom_range(0, 4) == 0)
				queue_op(FUNC_LOOKUP, known_key(), rand_payload());
			else
				queue_op(FUNC_INSERT, fresh_key(), rand_payload());
		end
		repeat (12) begin
			case ($urandom_range(0, 3))
				0: queue_op(FUNC_INSERT, known_key(), rand_payload());
				1: queue_op(FUNC_INSERT, fresh_key(), rand_payload());
				2: queue_op(FUNC_LOOKUP, known_key(), rand_payload());
				default: queue_op(FUNC_LOOKUP, fresh_key(), rand_payload());
			endcase
		end
	endtask

	task automatic mixed_round();
		int len;
		int r;
		len = $urandom_range(20, 90);
		if ($urandom_range(0, 1))
			queue_op(FUNC_CLEAR, fresh_key(), rand_payload());
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				queue_op(FUNC_INSERT, ($urandom_range(0, 4) == 0) ? known_key() : fresh_key(),
					rand_payload());
			else if (r < 85)
				queue_op(FUNC_LOOKUP, ($urandom_range(0, 99) < 65) ? known_key() : fresh_key(),
					rand_payload());
			else if (r < 88)
				queue_op(FUNC_SPARE, fresh_key(), rand_payload());
			else if (r < 90)
				queue_op(FUNC_CLEAR, fresh_key(), rand_payload());
			else
				queue_op(FUNC_INSERT, fresh_key(), rand_payload());
		end
	endtask

	// Request driver: one transfer at a time, gaps chosen after each transfer outside the back-to-back windows
	always @(negedge clk) begin : driver
		backlog_t nxt;
		if (arst_n) begin
			if (!req_valid || req_xfers == req_sent) begin
				if (req_valid && (req_sent / 80) % 4 != 3)
					gap_left = pick_gap();
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					req_valid <= 1'b0;
				end else if (req_backlog[0].drain) begin
					req_valid <= 1'b0;
					if (rsp_due.size() == 0)
						void'(req_backlog.pop_front());
				end else begin
					nxt = req_backlog.pop_front();
					req       <= nxt.body;
					req_valid <= 1'b1;
					req_sent++;
				end
			end
		end
	end

	// Response stall: random stalls, one long hold-off, and calm windows
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && rsp_seen >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if ((rsp_seen / 80) % 4 != 1)
					stall_left = pick_gap();
			end
		end
	end

	// Scoreboard: check responses first, then predict any request transfer
	always @(posedge clk) begin : scoreboard
		rsp_item_t want;
		rsp_item_t got;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen <= rsp_seen + 1;
				got = rsp;
				if (rsp_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: response with none pending: status %0d payload %h count %0d",
							$realtime, got.status, got.found_payload, got.entry_count);
				end else begin
					want = rsp_due.pop_front();
					if (got.status !== want.status || got.found_payload !== want.found_payload ||
						got.entry_count !== want.entry_count) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"%0t: mismatch: expected status %0d payload %h count %0d,",
								" got status %0d payload %h count %0d"},
								$realtime, want.status, want.found_payload, want.entry_count,
								got.status, got.found_payload, got.entry_count);
					end
				end
			end
			if (req_valid && !req_stall) begin
				req_xfers <= req_xfers + 1;
				want = table_apply(req);
				rsp_due.push_back(want);
				case (req.func)
					FUNC_INSERT: begin
						if (want.status == STAT_OK)
							n_stored++;
						else if (want.status == STAT_DUP)
							n_dup++;
						else
							n_full++;
					end
					FUNC_LOOKUP: begin
						if (want.status == STAT_OK)
							n_hit++;
						else
							n_miss++;
					end
					FUNC_CLEAR: n_clear++;
					default: ;
				endcase
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int round;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, key and payload extremes, duplicates, ignored code, clear
		queue_op(FUNC_LOOKUP, 64'd0, 32'd0);
		queue_op(FUNC_INSERT, 64'd0, 32'd0);
		queue_op(FUNC_INSERT, {64{1'b1}}, {32{1'b1}});
		queue_op(FUNC_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5);
		queue_op(FUNC_INSERT, 64'd0, 32'h1234_5678);
		queue_op(FUNC_LOOKUP, {64{1'b1}}, 32'd0);
		queue_op(FUNC_LOOKUP, 64'd0, {32{1'b1}});
		queue_op(FUNC_LOOKUP, 64'd1, 32'd0);
		queue_op(FUNC_SPARE, {64{1'b1}}, {32{1'b1}});
		queue_op(FUNC_INSERT, 64'd5, 32'h0000_0005);
		queue_op(FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h5A5A_5A5A);
		queue_op(FUNC_LOOKUP, 64'd5, 32'd0);
		queue_op(FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'd0);
		queue_op(FUNC_INSERT, {64{1'b1}}, 32'd7);
		queue_op(FUNC_CLEAR, 64'd0, 32'd0);
		queue_op(FUNC_LOOKUP, {64{1'b1}}, 32'd0);
		queue_op(FUNC_INSERT, {64{1'b1}}, 32'h5A5A_5A5A);
		queue_op(FUNC_LOOKUP, {64{1'b1}}, 32'd0);
		queue_op(FUNC_SPARE, 64'd0, 32'd0);
		queue_op(FUNC_CLEAR, {64{1'b1}}, {32{1'b1}});
		queue_op(FUNC_LOOKUP, 64'd0, 32'd0);
		queue_drain();

		// random rounds; the first two fill the table
		round = 0;
		while (n_queued < ITEM_TARGET) begin
			if (round < 2 || $urandom_range(0, 4) == 0)
				fill_round();
			else
				mixed_round();
			if (round == 0 || $urandom_range(0, 3) == 0)
				queue_drain();
			round++;
		end

		while (req_backlog.size() != 0 || req_xfers != req_sent)
			@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d requests: %0d inserts stored, %0d duplicates and %0d full-table refusals,",
			req_xfers, n_stored, n_dup, n_full);
		$display("%0d lookup hits, %0d lookup misses, %0d clears; %0d mismatches",
			n_hit, n_miss, n_clear, err_cnt);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
